// ===== hw/rtl/sbms_pkg.sv =====
// ---------------------------------------------------------------------------
// sbms_pkg: shared types for the block motion search
// Sequencer states and the result record passed to the output stage.
// ---------------------------------------------------------------------------
package sbms_pkg;

    localparam int CFG_X_LOW  = 0;
    localparam int CFG_X_HIGH = 1;
    localparam int CFG_Y_LOW  = 2;
    localparam int CFG_Y_HIGH = 3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_ACC,
        ST_CAND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3:0]  block_number;
        logic [3:0]  shift_x;
        logic [3:0]  shift_y;
        logic [15:0] best_cost;
        logic        final_block;
    } result_t;

endpackage

// ===== hw/rtl/sad_block_motion_search_top.sv =====
// ---------------------------------------------------------------------------
// sad_block_motion_search_top: full-search SAD block matcher
// Pixel store in two RAMs, sequencer walking blocks and candidates.
// ---------------------------------------------------------------------------
// Slave side takes one pixel pair per beat, one beat per cycle, while loading.
// After the last pixel of the frame the input stalls (s_tready low) and the
// search runs: each candidate reads its BLOCK_X*BLOCK_Y pixel pairs through the
// one-read-per-cycle port of each pixel RAM, ST_ACC adds the last difference
// and ST_CAND compares the cost. After the last candidate of a block, ST_EMIT
// hands its result beat to a one-entry output register. If the master stalls,
// the sequencer waits with its result until the register frees up.
// Reset clears counters, the window registers (-4,4,-4,4) and the output
// valid; the pixel RAMs are not cleared (each frame rewrites the part that is read).
// The user writes registers over cfg_we/cfg_addr/cfg_wdata only while idle; the block
// itself does not enforce it. Bounds are clamped to [-MAX_SHIFT,0] and [0,MAX_SHIFT].
// ---------------------------------------------------------------------------
module sad_block_motion_search_top
    import sbms_pkg::*;
#(
    parameter int BLOCK_X   = 8,
    parameter int BLOCK_Y   = 8,
    parameter int BLOCKS_X  = 4,
    parameter int BLOCKS_Y  = 4,
    parameter int MAX_SHIFT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel_first[7:0], pixel_second[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // block_number, shift_x, shift_y, best_cost, pad
    output logic        m_tlast    // final_block
);

    localparam int ROWS_MAX = BLOCKS_X * BLOCK_X + 2 * MAX_SHIFT;
    localparam int COLS_MAX = BLOCKS_Y * BLOCK_Y + 2 * MAX_SHIFT;
    localparam int DEPTH    = ROWS_MAX * COLS_MAX;
    localparam int AW       = $clog2(DEPTH + 1);
    localparam int RW       = $clog2(ROWS_MAX + 1);
    localparam int CW       = $clog2(COLS_MAX + 1);
    localparam int IXW      = $clog2(BLOCK_X + 1);
    localparam int IYW      = $clog2(BLOCK_Y + 1);
    localparam int BXW      = $clog2(BLOCKS_X + 1);
    localparam int BYW      = $clog2(BLOCKS_Y + 1);
    localparam int NB       = BLOCKS_X * BLOCKS_Y;

    logic [2:0] xl_reg, xh_reg, yl_reg, yh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xl_reg <= 3'd4;
            xh_reg <= 3'd4;
            yl_reg <= 3'd4;
            yh_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                2'(CFG_X_LOW):  xl_reg <= cfg_wdata;
                2'(CFG_X_HIGH): xh_reg <= cfg_wdata;
                2'(CFG_Y_LOW):  yl_reg <= cfg_wdata;
                2'(CFG_Y_HIGH): yh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped bounds: neg = -low (0..MAX_SHIFT), pos = high
    function automatic logic [3:0] neg_of(input logic [2:0] r);
        logic [3:0] v;
        v = r[2] ? 4'(4'd8 - {1'b0, r}) : 4'd0;
        if (v > 4'(MAX_SHIFT)) v = 4'(MAX_SHIFT);
        return v;
    endfunction

    function automatic logic [3:0] pos_of(input logic [2:0] r);
        logic [3:0] v;
        v = {1'b0, r};
        if (v > 4'(MAX_SHIFT)) v = 4'(MAX_SHIFT);
        return v;
    endfunction

    logic [3:0] nx, px, ny, py;
    logic [RW-1:0] rows;
    logic [CW-1:0] cols;
    logic [AW+RW-1:0] size_full;

    assign nx = neg_of(xl_reg);
    assign px = pos_of(xh_reg);
    assign ny = neg_of(yl_reg);
    assign py = pos_of(yh_reg);
    assign rows = RW'(BLOCKS_X * BLOCK_X) + RW'(px) + RW'(nx);
    assign cols = CW'(BLOCKS_Y * BLOCK_Y) + CW'(py) + CW'(ny);
    assign size_full = (AW+RW)'(rows) * (AW+RW)'(cols);

    logic [7:0] mem_a [DEPTH];
    logic [7:0] mem_b [DEPTH];
    logic [7:0] rd_a, rd_b;

    state_t state_reg, state_next;
    logic [10:0] load_reg;
    logic [BXW-1:0] bx_reg;
    logic [BYW-1:0] by_reg;
    logic [3:0] sxo_reg, syo_reg;        // displacement + neg, 0..2*MAX_SHIFT
    logic [IXW-1:0] ix_reg;
    logic [IYW-1:0] iy_reg;
    logic [15:0] acc_reg, best_reg;
    logic [3:0] bsx_reg, bsy_reg;
    logic [AW-1:0] addr_a_reg, addr_b_reg;
    logic rd_valid_reg;
    logic out_full;
    result_t res;

    logic accept;
    assign s_tready = (state_reg == ST_LOAD);
    assign accept = s_tvalid && s_tready;

    logic [10:0] load_inc;
    assign load_inc = load_reg + 11'd1;

    logic load_done;
    assign load_done = ((AW+RW)'(load_inc) >= size_full) || (load_inc == 11'd0);

    // address generation, one pixel pair per cycle
    logic [RW-1:0] ra, rb;
    logic [CW-1:0] ca, cb;
    logic last_pix;
    assign ra = RW'(nx) + RW'(bx_reg * BLOCK_X) + RW'(ix_reg);
    assign ca = CW'(ny) + CW'(by_reg * BLOCK_Y) + CW'(iy_reg);
    assign rb = RW'(bx_reg * BLOCK_X) + RW'(sxo_reg) + RW'(ix_reg);
    assign cb = CW'(by_reg * BLOCK_Y) + CW'(syo_reg) + CW'(iy_reg);
    assign last_pix = (ix_reg == IXW'(BLOCK_X - 1)) && (iy_reg == IYW'(BLOCK_Y - 1));

    logic [AW+CW-1:0] pa_full, pb_full;
    assign pa_full = (AW+CW)'(ra) * (AW+CW)'(cols) + (AW+CW)'(ca);
    assign pb_full = (AW+CW)'(rb) * (AW+CW)'(cols) + (AW+CW)'(cb);

    always_ff @(posedge clk)
    begin
        if (accept && ({1'b0, load_reg} < 12'(DEPTH)))
        begin
            mem_a[load_reg[AW-1:0]] <= s_tdata[7:0];
            mem_b[load_reg[AW-1:0]] <= s_tdata[15:8];
        end
        rd_a <= mem_a[pa_full[AW-1:0]];
        rd_b <= mem_b[pb_full[AW-1:0]];
    end

    logic cand_last_y, cand_last_x, blk_last;
    assign cand_last_y = (syo_reg == 4'(ny + py));
    assign cand_last_x = (sxo_reg == 4'(nx + px));
    assign blk_last = (bx_reg == BXW'(BLOCKS_X - 1)) && (by_reg == BYW'(BLOCKS_Y - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (accept && load_done) state_next = ST_READ;
            ST_READ: if (last_pix) state_next = ST_ACC;
            ST_ACC:  state_next = ST_CAND;
            ST_CAND: state_next = (cand_last_x && cand_last_y) ? ST_EMIT : ST_READ;
            ST_EMIT: if (!out_full) state_next = blk_last ? ST_LOAD : ST_READ;
            default: state_next = ST_LOAD;
        endcase
    end

    logic [7:0] absd;
    assign absd = (rd_a > rd_b) ? rd_a - rd_b : rd_b - rd_a;

    logic [15:0] acc_sum;
    assign acc_sum = acc_reg + 16'(absd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_reg     <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            sxo_reg      <= '0;
            syo_reg      <= '0;
            ix_reg       <= '0;
            iy_reg       <= '0;
            acc_reg      <= '0;
            best_reg     <= 16'hFFFF;
            bsx_reg      <= '0;
            bsy_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_READ);
            if (rd_valid_reg)
            begin
                acc_reg <= acc_sum;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        load_reg <= load_done ? 11'd0 : load_inc;
                        if (load_done)
                        begin
                            bx_reg <= '0; by_reg <= '0;
                            sxo_reg <= '0; syo_reg <= '0;
                            ix_reg <= '0; iy_reg <= '0;
                            acc_reg <= '0;
                            best_reg <= 16'hFFFF;
                        end
                    end
                end
                ST_READ:
                begin
                    if (iy_reg == IYW'(BLOCK_Y - 1))
                    begin
                        iy_reg <= '0;
                        ix_reg <= (ix_reg == IXW'(BLOCK_X - 1)) ? '0 : ix_reg + 1'b1;
                    end
                    else
                    begin
                        iy_reg <= iy_reg + 1'b1;
                    end
                end
                ST_ACC: ;
                ST_CAND:
                begin
                    acc_reg <= '0;
                    if (acc_reg < best_reg)
                    begin
                        best_reg <= acc_reg;
                        bsx_reg  <= sxo_reg - nx;
                        bsy_reg  <= syo_reg - ny;
                    end
                    if (cand_last_y)
                    begin
                        syo_reg <= '0;
                        sxo_reg <= cand_last_x ? 4'd0 : sxo_reg + 4'd1;
                    end
                    else
                    begin
                        syo_reg <= syo_reg + 4'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_full)
                    begin
                        best_reg <= 16'hFFFF;
                        bsx_reg  <= '0;
                        bsy_reg  <= '0;
                        if (by_reg == BYW'(BLOCKS_Y - 1))
                        begin
                            by_reg <= '0;
                            bx_reg <= bx_reg + 1'b1;
                        end
                        else
                        begin
                            by_reg <= by_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    logic [7:0] bnum;
    assign bnum = 8'(bx_reg * BLOCKS_Y) + 8'(by_reg);

    always_comb
    begin
        res.block_number = bnum[3:0];
        res.shift_x      = bsx_reg;
        res.shift_y      = bsy_reg;
        res.best_cost    = best_reg;
        res.final_block  = (bnum == 8'(NB - 1));
    end

    result_t dout;

    sbms_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   ((state_reg == ST_EMIT) && !out_full),
        .din    (res),
        .full   (out_full),
        .tvalid (m_tvalid),
        .tready (m_tready),
        .dout   (dout)
    );

    assign m_tdata = {4'b0000, dout.best_cost, dout.shift_y, dout.shift_x, dout.block_number};
    assign m_tlast = dout.final_block;

endmodule

// ===== hw/rtl/sbms_outbuf.sv =====
// ---------------------------------------------------------------------------
// sbms_outbuf: one-entry result register
// Holds a result beat until the master side takes it.
// ---------------------------------------------------------------------------
module sbms_outbuf
    import sbms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t din,
    output logic    full,
    output logic    tvalid,
    input  logic    tready,
    output result_t dout
);

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= din;
        end
    end

    assign full   = valid_reg && !tready;
    assign tvalid = valid_reg;
    assign dout   = data_reg;

endmodule

// ===== hw/rtl/sbms_checker.sv =====
// ---------------------------------------------------------------------------
// sbms_checker: port-level checks
// Watches the stream ports of the motion search top level.
// ---------------------------------------------------------------------------
module sbms_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:28] == 4'b0000)
        else $error("pad bits set");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("beat right after last block");

    a_nomix: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open while search results pending");

endmodule

bind sad_block_motion_search_top sbms_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
